// ===== design/ams_pkg.sv =====
// shared constants, codes and control struct for the adjacency matrix store
`default_nettype none

package ams_pkg;

    // default table size
    localparam int MAX_VERTICES_DEF = 32;

    // fixed payload widths
    localparam int CMD_W   = 3;
    localparam int NAME_W  = 6;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int LABEL_W = 6;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD_VERTEX = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_VERTEX = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_EDGE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY_EDGE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY_NAME = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

    // write controls from the sequencer to the storage
    typedef struct packed {
        logic adj_we;
        logic name_we;
        logic clear;
    } t_mem_ctrl;

endpackage

`default_nettype wire

// ===== design/ams_store.sv =====
// adjacency row memory and name memory with per-entry valid bits
`default_nettype none

module ams_store #(
    parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF,
    parameter int IW           = $clog2(MAX_VERTICES),
    parameter int CW           = $clog2(MAX_VERTICES + 1)
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ams_pkg::t_mem_ctrl i_ctrl,
    input  wire  [IW-1:0]           i_adj_waddr,
    input  wire  [MAX_VERTICES-1:0] i_adj_wdata,
    input  wire  [IW-1:0]           i_adj_raddr,
    output logic [MAX_VERTICES-1:0] o_adj_rdata,
    input  wire  [IW-1:0]           i_name_waddr,
    input  wire  [CW-1:0]           i_name_wdata,
    input  wire  [IW-1:0]           i_name_raddr,
    output logic [CW-1:0]           o_name_rdata
);

    logic [MAX_VERTICES-1:0] r_adj_mem [MAX_VERTICES];
    logic [CW-1:0]           r_name_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_name_vld;
    logic [MAX_VERTICES-1:0] r_adj_q;
    logic                    r_adj_qv;
    logic [CW-1:0]           r_name_q;
    logic                    r_name_qv;
    logic [IW-1:0]           r_name_ra;

    // valid bits, cleared at reset and on rebuild
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_row_vld  <= '0;
            r_name_vld <= '0;
        end else begin
            if (i_ctrl.adj_we) begin
                r_row_vld[i_adj_waddr] <= 1'b1;
            end
            if (i_ctrl.name_we) begin
                r_name_vld[i_name_waddr] <= 1'b1;
            end
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.adj_we) begin
            r_adj_mem[i_adj_waddr] <= i_adj_wdata;
        end
        if (i_ctrl.name_we) begin
            r_name_mem[i_name_waddr] <= i_name_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_adj_q   <= r_adj_mem[i_adj_raddr];
        r_adj_qv  <= r_row_vld[i_adj_raddr];
        r_name_q  <= r_name_mem[i_name_raddr];
        r_name_qv <= r_name_vld[i_name_raddr];
        r_name_ra <= i_name_raddr;
    end

    // a row never written reads as zero, a name never written as position plus one
    assign o_adj_rdata  = r_adj_qv ? r_adj_q : '0;
    assign o_name_rdata = r_name_qv ? r_name_q : (CW'(r_name_ra) + CW'(1));

endmodule

`default_nettype wire

// ===== design/adjacency_matrix_store.sv =====
// undirected graph store: adjacency bit matrix, vertex names and vertex count
//
// input beats (i_valid / o_ready) carry a command with two names and two
// positions; each beat produces exactly one result beat (o_valid / i_ready)
// with status, vertex count, edge bit and vertex label.
// one command runs at a time under a small sequencer; o_ready is high only
// while the sequencer is idle. steps of each command, n = vertex count:
//   add vertex, unused codes: dispatch only; queries: dispatch, then a registered read when in range
//   add / delete edge: name scan, then two row read-modify-writes
//   delete vertex: name scan, then one row and name shift per cycle
// the name scan reads one name memory entry per cycle and the row compaction
// pushes one adjacency row per cycle through a shared shift unit, so both
// scale with n (up to MAX_VERTICES).
// a finished result sits in an output register; the next beat is accepted
// while it waits, and the sequencer holds its next result until i_ready.
// reset (synchronous, active low) empties the store; writing i_cfg_wdata
// with i_cfg_we while idle rebuilds it with vertices 1..value (saturated) and no
// edges. both take effect at once through per-row valid bits, with no clearing pass.
`default_nettype none

module adjacency_matrix_store #(
    parameter int MAX_VERTICES = ams_pkg::MAX_VERTICES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [ams_pkg::NAME_W-1:0]   i_cfg_wdata,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [ams_pkg::CMD_W-1:0]    i_command,
    input  wire  [ams_pkg::NAME_W-1:0]   i_name_a,
    input  wire  [ams_pkg::NAME_W-1:0]   i_name_b,
    input  wire  [ams_pkg::POS_W-1:0]    i_row_index,
    input  wire  [ams_pkg::POS_W-1:0]    i_col_index,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [ams_pkg::STAT_W-1:0]   o_status,
    output logic [ams_pkg::NAME_W-1:0]   o_vertex_count,
    output logic                         o_edge_bit,
    output logic [ams_pkg::LABEL_W-1:0]  o_vertex_label
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > ams_pkg::NAME_W) ? CW : ams_pkg::NAME_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_LOOK = 4'd2;
    localparam logic [3:0] S_EWA  = 4'd3;
    localparam logic [3:0] S_EWB  = 4'd4;
    localparam logic [3:0] S_DEL  = 4'd5;
    localparam logic [3:0] S_QD   = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0]                   r_state, n_state;
    logic [ams_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [ams_pkg::NAME_W-1:0]   r_na, n_na;
    logic [ams_pkg::NAME_W-1:0]   r_nb, n_nb;
    logic [ams_pkg::POS_W-1:0]    r_row, n_row;
    logic [ams_pkg::POS_W-1:0]    r_col, n_col;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_lv, n_lv;
    logic [IW-1:0]                r_lidx, n_lidx;
    logic                         r_fa, n_fa;
    logic                         r_fb, n_fb;
    logic [IW-1:0]                r_pa, n_pa;
    logic [IW-1:0]                r_pb, n_pb;
    logic                         r_wv, n_wv;
    logic [IW-1:0]                r_wdst, n_wdst;
    logic [ams_pkg::STAT_W-1:0]   r_status, n_status;
    logic                         r_bit, n_bit;
    logic [CW-1:0]                r_label, n_label;
    logic                         r_ovalid, n_ovalid;
    logic [ams_pkg::STAT_W-1:0]   r_o_status, n_o_status;
    logic [ams_pkg::NAME_W-1:0]   r_o_count, n_o_count;
    logic                         r_o_bit, n_o_bit;
    logic [ams_pkg::LABEL_W-1:0]  r_o_label, n_o_label;

    ams_pkg::t_mem_ctrl           mem_ctrl;
    logic [IW-1:0]                adj_waddr;
    logic [MAX_VERTICES-1:0]      adj_wdata;
    logic [IW-1:0]                adj_raddr;
    logic [MAX_VERTICES-1:0]      adj_rdata;
    logic [IW-1:0]                name_waddr;
    logic [CW-1:0]                name_wdata;
    logic [IW-1:0]                name_raddr;
    logic [CW-1:0]                name_rdata;
    logic [MAX_VERTICES-1:0]      low_mask;
    logic [MAX_VERTICES-1:0]      row_compact;

    ams_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .IW           (IW),
        .CW           (CW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (mem_ctrl),
        .i_adj_waddr  (adj_waddr),
        .i_adj_wdata  (adj_wdata),
        .i_adj_raddr  (adj_raddr),
        .o_adj_rdata  (adj_rdata),
        .i_name_waddr (name_waddr),
        .i_name_wdata (name_wdata),
        .i_name_raddr (name_raddr),
        .o_name_rdata (name_rdata)
    );

    // shared shift unit: drop column pa from a row, upper bits move down one
    assign low_mask    = (MAX_VERTICES'(1) << r_pa) - MAX_VERTICES'(1);
    assign row_compact = (adj_rdata & low_mask) | ((adj_rdata >> 1) & ~low_mask);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_vertex_count = r_o_count;
    assign o_edge_bit     = r_o_bit;
    assign o_vertex_label = r_o_label;

    // sequencer
    always_comb begin
        logic [MAX_VERTICES-1:0] row_mod;
        logic [CW-1:0]           src;
        logic                    edge_val;

        n_state    = r_state;
        n_cmd      = r_cmd;
        n_na       = r_na;
        n_nb       = r_nb;
        n_row      = r_row;
        n_col      = r_col;
        n_count    = r_count;
        n_idx      = r_idx;
        n_lv       = r_lv;
        n_lidx     = r_lidx;
        n_fa       = r_fa;
        n_fb       = r_fb;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_wv       = r_wv;
        n_wdst     = r_wdst;
        n_status   = r_status;
        n_bit      = r_bit;
        n_label    = r_label;
        n_ovalid   = r_ovalid & ~i_ready;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_bit    = r_o_bit;
        n_o_label  = r_o_label;
        mem_ctrl   = '0;
        adj_waddr  = r_wdst;
        adj_wdata  = '0;
        adj_raddr  = '0;
        name_waddr = '0;
        name_wdata = '0;
        name_raddr = '0;
        row_mod    = adj_rdata;
        src        = '0;
        edge_val   = (r_cmd == ams_pkg::CMD_ADD_EDGE);

        case (r_state)
            S_IDLE: begin
                // rebuild on a register write
                if (i_cfg_we) begin
                    mem_ctrl.clear = 1'b1;
                    n_count = (NW'(i_cfg_wdata) > NW'(MAX_VERTICES)) ? CNT_MAX
                                                                     : CW'(i_cfg_wdata);
                end
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_na     = i_name_a;
                    n_nb     = i_name_b;
                    n_row    = i_row_index;
                    n_col    = i_col_index;
                    n_status = ams_pkg::ST_DONE;
                    n_bit    = 1'b0;
                    n_label  = '0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd)
                    ams_pkg::CMD_ADD_VERTEX: begin
                        // new row and column are already zero
                        if (r_count == CNT_MAX) begin
                            n_status = ams_pkg::ST_FULL;
                        end else begin
                            mem_ctrl.name_we = 1'b1;
                            name_waddr = IW'(r_count);
                            name_wdata = r_count + CW'(1);
                            n_count    = r_count + CW'(1);
                        end
                        n_state = S_FIN;
                    end
                    ams_pkg::CMD_ADD_EDGE, ams_pkg::CMD_DEL_EDGE,
                    ams_pkg::CMD_DEL_VERTEX: begin
                        n_idx   = '0;
                        n_lv    = 1'b0;
                        n_fa    = 1'b0;
                        n_fb    = 1'b0;
                        n_state = S_LOOK;
                    end
                    ams_pkg::CMD_QUERY_EDGE: begin
                        adj_raddr = IW'(r_row);
                        if (NW'(r_row) >= NW'(r_count) || NW'(r_col) >= NW'(r_count)) begin
                            n_status = ams_pkg::ST_RANGE;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_QD;
                        end
                    end
                    ams_pkg::CMD_QUERY_NAME: begin
                        name_raddr = IW'(r_row);
                        if (NW'(r_row) >= NW'(r_count)) begin
                            n_status = ams_pkg::ST_RANGE;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_QD;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_QD: begin
                if (r_cmd == ams_pkg::CMD_QUERY_EDGE) begin
                    n_bit = adj_rdata[IW'(r_col)];
                end else begin
                    n_label = name_rdata;
                end
                n_state = S_FIN;
            end
            S_LOOK: begin
                // scan names, one read issued per cycle, lowest match kept
                name_raddr = IW'(r_idx);
                if (r_idx < r_count) begin
                    n_idx  = r_idx + CW'(1);
                    n_lv   = 1'b1;
                    n_lidx = IW'(r_idx);
                end else begin
                    n_lv = 1'b0;
                end
                if (r_lv) begin
                    if (!r_fa && NW'(name_rdata) == NW'(r_na)) begin
                        n_fa = 1'b1;
                        n_pa = r_lidx;
                    end
                    if (!r_fb && NW'(name_rdata) == NW'(r_nb)) begin
                        n_fb = 1'b1;
                        n_pb = r_lidx;
                    end
                end
                if (r_idx == r_count && !r_lv) begin
                    if (r_cmd == ams_pkg::CMD_DEL_VERTEX) begin
                        if (!r_fa) begin
                            n_status = ams_pkg::ST_IGNORED;
                            n_state  = S_FIN;
                        end else begin
                            n_idx   = '0;
                            n_wv    = 1'b0;
                            n_state = S_DEL;
                        end
                    end else if (!r_fa || !r_fb) begin
                        n_status = ams_pkg::ST_IGNORED;
                        n_state  = S_FIN;
                    end else if (edge_val && r_pa == r_pb) begin
                        // self loop is dropped
                        n_state = S_FIN;
                    end else begin
                        adj_raddr = r_pa;
                        n_state   = S_EWA;
                    end
                end
            end
            S_EWA: begin
                // write row pa, fetch row pb
                row_mod[r_pb]   = edge_val;
                mem_ctrl.adj_we = 1'b1;
                adj_waddr       = r_pa;
                adj_wdata       = row_mod;
                adj_raddr       = r_pb;
                n_state         = S_EWB;
            end
            S_EWB: begin
                row_mod[r_pa]   = edge_val;
                mem_ctrl.adj_we = 1'b1;
                adj_waddr       = r_pb;
                adj_wdata       = row_mod;
                n_state         = S_FIN;
            end
            S_DEL: begin
                // write back the row fetched last cycle
                if (r_wv) begin
                    mem_ctrl.adj_we = 1'b1;
                    adj_waddr = r_wdst;
                    adj_wdata = (CW'(r_wdst) == r_count - CW'(1)) ? '0 : row_compact;
                    if (r_wdst >= r_pa && CW'(r_wdst) != r_count - CW'(1)) begin
                        mem_ctrl.name_we = 1'b1;
                        name_waddr = r_wdst;
                        name_wdata = name_rdata;
                    end
                end
                // fetch source for the next destination row
                if (r_idx < r_count) begin
                    src        = (r_idx < CW'(r_pa)) ? r_idx : r_idx + CW'(1);
                    adj_raddr  = IW'(src);
                    name_raddr = IW'(src);
                    n_wv       = 1'b1;
                    n_wdst     = IW'(r_idx);
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_wv = 1'b0;
                    if (!r_wv) begin
                        n_count = r_count - CW'(1);
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // hand over to the output register once it is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_count  = ams_pkg::NAME_W'(r_count);
                    n_o_bit    = r_bit;
                    n_o_label  = ams_pkg::LABEL_W'(r_label);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_lv     <= 1'b0;
            r_wv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_lv     <= n_lv;
            r_wv     <= n_wv;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_na       <= n_na;
        r_nb       <= n_nb;
        r_row      <= n_row;
        r_col      <= n_col;
        r_idx      <= n_idx;
        r_lidx     <= n_lidx;
        r_fa       <= n_fa;
        r_fb       <= n_fb;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_wdst     <= n_wdst;
        r_status   <= n_status;
        r_bit      <= n_bit;
        r_label    <= n_label;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_bit    <= n_o_bit;
        r_o_label  <= n_o_label;
    end

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a command is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("vertex count above table size");

    a_del_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |-> (r_idx <= r_count))
        else $error("compaction ran past the vertex count");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ovalid && !i_ready) |=> (r_state == S_FIN))
        else $error("result overwrote a waiting output beat");

endmodule

`default_nettype wire

// ===== tb/sv/adjacency_matrix_store_test.sv =====
// self-checking testbench for the adjacency matrix store: directed cases, then random graph traffic
`default_nettype none

module adjacency_matrix_store_test;

    localparam int MAXV        = ams_pkg::MAX_VERTICES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_BEATS = 385;
    // slowest command is a vertex delete on a full store, plus margin
    localparam int TAIL_CYCLES = 2 * MAXV + 32;

    // command codes with no operation behind them
    localparam logic [ams_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [ams_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ams_pkg::STAT_W-1:0]  status;
        logic [ams_pkg::NAME_W-1:0]  vertex_count;
        logic                        edge_bit;
        logic [ams_pkg::LABEL_W-1:0] vertex_label;
    } t_graph_result;

    // dut ports
    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [ams_pkg::NAME_W-1:0]  i_cfg_wdata = '0;
    logic                        i_valid     = 1'b0;
    logic                        o_ready;
    logic [ams_pkg::CMD_W-1:0]   i_command   = '0;
    logic [ams_pkg::NAME_W-1:0]  i_name_a    = '0;
    logic [ams_pkg::NAME_W-1:0]  i_name_b    = '0;
    logic [ams_pkg::POS_W-1:0]   i_row_index = '0;
    logic [ams_pkg::POS_W-1:0]   i_col_index = '0;
    logic                        o_valid;
    logic                        i_ready     = 1'b0;
    logic [ams_pkg::STAT_W-1:0]  o_status;
    logic [ams_pkg::NAME_W-1:0]  o_vertex_count;
    logic                        o_edge_bit;
    logic [ams_pkg::LABEL_W-1:0] o_vertex_label;

    // graph mirror kept in step with accepted beats
    logic [MAXV-1:0]             adj_row [MAXV] = '{default: '0};
    logic [ams_pkg::NAME_W-1:0]  vertex_name [MAXV] = '{default: '0};
    int                          vertex_total = 0;

    t_graph_result      expected_results [$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int rebuilds        = 0;
    int full_rejects    = 0;
    int vertex_deletes  = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    adjacency_matrix_store dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_name_a       (i_name_a),
        .i_name_b       (i_name_b),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_vertex_count (o_vertex_count),
        .o_edge_bit     (o_edge_bit),
        .o_vertex_label (o_vertex_label)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // lowest live position holding a name, -1 when absent
    function automatic int find_position(input logic [ams_pkg::NAME_W-1:0] name);
        int i;
        for (i = 0; i < vertex_total; i++)
            if (vertex_name[i] == name)
                return i;
        return -1;
    endfunction

    // apply one command to the mirror and return the result it should give
    function automatic t_graph_result apply_command(
        input logic [ams_pkg::CMD_W-1:0]  cmd,
        input logic [ams_pkg::NAME_W-1:0] name_a,
        input logic [ams_pkg::NAME_W-1:0] name_b,
        input logic [ams_pkg::POS_W-1:0]  row,
        input logic [ams_pkg::POS_W-1:0]  col
    );
        t_graph_result r;
        int pa, pb, i, j, n;
        r = '0;
        case (cmd)
            ams_pkg::CMD_ADD_VERTEX: begin
                if (vertex_total >= MAXV) begin
                    r.status = ams_pkg::ST_FULL;
                    full_rejects++;
                end else begin
                    for (i = 0; i <= vertex_total; i++) begin
                        adj_row[vertex_total][i] = 1'b0;
                        adj_row[i][vertex_total] = 1'b0;
                    end
                    vertex_name[vertex_total] = ams_pkg::NAME_W'(vertex_total + 1);
                    vertex_total++;
                end
            end
            ams_pkg::CMD_ADD_EDGE, ams_pkg::CMD_DEL_EDGE: begin
                pa = find_position(name_a);
                pb = find_position(name_b);
                if (pa < 0 || pb < 0) begin
                    r.status = ams_pkg::ST_IGNORED;
                end else if (cmd == ams_pkg::CMD_DEL_EDGE || pa != pb) begin
                    // self loops are dropped on add only
                    adj_row[pa][pb] = (cmd == ams_pkg::CMD_ADD_EDGE);
                    adj_row[pb][pa] = (cmd == ams_pkg::CMD_ADD_EDGE);
                end
            end
            ams_pkg::CMD_DEL_VERTEX: begin
                pa = find_position(name_a);
                if (pa < 0) begin
                    r.status = ams_pkg::ST_IGNORED;
                end else begin
                    // pull rows up, then columns left, then clear the freed slot
                    n = vertex_total;
                    for (i = pa; i + 1 < n; i++) begin
                        adj_row[i] = adj_row[i + 1];
                        vertex_name[i] = vertex_name[i + 1];
                    end
                    for (i = 0; i < n; i++)
                        for (j = pa; j + 1 < n; j++)
                            adj_row[i][j] = adj_row[i][j + 1];
                    adj_row[n - 1] = '0;
                    for (i = 0; i < n; i++)
                        adj_row[i][n - 1] = 1'b0;
                    vertex_name[n - 1] = '0;
                    vertex_total = n - 1;
                    vertex_deletes++;
                end
            end
            ams_pkg::CMD_QUERY_EDGE: begin
                if (row >= vertex_total || col >= vertex_total)
                    r.status = ams_pkg::ST_RANGE;
                else
                    r.edge_bit = adj_row[row][col];
            end
            ams_pkg::CMD_QUERY_NAME: begin
                if (row >= vertex_total)
                    r.status = ams_pkg::ST_RANGE;
                else
                    r.vertex_label = vertex_name[row];
            end
            default: begin
            end
        endcase
        r.vertex_count = ams_pkg::NAME_W'(vertex_total);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin : check_result
        t_graph_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: status %0d count %0d", o_status, o_vertex_count);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_vertex_count !== want.vertex_count) begin
                    $error("vertex_count: expected %0d, got %0d",
                           want.vertex_count, o_vertex_count);
                    mismatch_count++;
                end
                if (o_edge_bit !== want.edge_bit) begin
                    $error("edge_bit: expected %0d, got %0d", want.edge_bit, o_edge_bit);
                    mismatch_count++;
                end
                if (o_vertex_label !== want.vertex_label) begin
                    $error("vertex_label: expected %0d, got %0d",
                           want.vertex_label, o_vertex_label);
                    mismatch_count++;
                end
            end
        end
    end

    // send one command beat; valid is left high after the handshake
    task automatic send_command(
        input logic [ams_pkg::CMD_W-1:0]  cmd,
        input logic [ams_pkg::NAME_W-1:0] name_a,
        input logic [ams_pkg::NAME_W-1:0] name_b,
        input logic [ams_pkg::POS_W-1:0]  row,
        input logic [ams_pkg::POS_W-1:0]  col
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_name_a    <= name_a;
        i_name_b    <= name_b;
        i_row_index <= row;
        i_col_index <= col;
        do @(posedge i_clk); while (!o_ready);
        expected_results.push_back(apply_command(cmd, name_a, name_b, row, col));
        commands_sent++;
    endtask

    // drop valid and hold off until every result is back
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // rebuild the store; only called with the block idle
    task automatic write_start_count(input logic [ams_pkg::NAME_W-1:0] value);
        int i, n;
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n = (value > MAXV) ? MAXV : int'(value);
        for (i = 0; i < MAXV; i++) begin
            adj_row[i]     = '0;
            vertex_name[i] = (i < n) ? ams_pkg::NAME_W'(i + 1) : '0;
        end
        vertex_total = n;
        rebuilds++;
    endtask

    // mostly live names, sometimes anything the field holds
    function automatic logic [ams_pkg::NAME_W-1:0] pick_name();
        if (vertex_total > 0 && $urandom_range(9) < 8)
            return vertex_name[$urandom_range(vertex_total - 1)];
        return ams_pkg::NAME_W'($urandom_range(63));
    endfunction

    function automatic logic [ams_pkg::POS_W-1:0] pick_position();
        if (vertex_total > 0 && $urandom_range(9) < 8)
            return ams_pkg::POS_W'($urandom_range(vertex_total - 1));
        return ams_pkg::POS_W'($urandom_range(31));
    endfunction

    // weighted command mix that keeps the vertex count moving
    task automatic send_random_command();
        int pick, add_weight;
        logic [ams_pkg::CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        add_weight = (vertex_total < 8) ? 24 : (vertex_total > 26) ? 8 : 14;
        if (pick < 2)
            cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
        else if (pick < 2 + add_weight)
            cmd = ams_pkg::CMD_ADD_VERTEX;
        else if (pick < 40)
            cmd = ams_pkg::CMD_ADD_EDGE;
        else if (pick < 52)
            cmd = ams_pkg::CMD_DEL_VERTEX;
        else if (pick < 62)
            cmd = ams_pkg::CMD_DEL_EDGE;
        else if (pick < 82)
            cmd = ams_pkg::CMD_QUERY_EDGE;
        else
            cmd = ams_pkg::CMD_QUERY_NAME;
        send_command(cmd, pick_name(), pick_name(), pick_position(), pick_position());
    endtask

    // queries, an edge add and a vertex delete against an empty store, plus the unused codes
    task automatic test_empty_store();
        send_command(ams_pkg::CMD_QUERY_EDGE, 6'd0, 6'd0, 5'd0, 5'd31);
        send_command(ams_pkg::CMD_QUERY_NAME, 6'd0, 6'd0, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_ADD_EDGE, 6'd1, 6'd2, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_DEL_VERTEX, 6'd0, 6'd0, 5'd0, 5'd0);
        send_command(CMD_SPARE_6, 6'd63, 6'd63, 5'd31, 5'd31);
        send_command(CMD_SPARE_7, 6'd0, 6'd0, 5'd0, 5'd0);
    endtask

    // symmetric edges, self loop, delete with compaction, duplicate names
    task automatic test_edges_and_compaction();
        repeat (3) send_command(ams_pkg::CMD_ADD_VERTEX, 6'd0, 6'd0, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_ADD_EDGE, 6'd1, 6'd3, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_ADD_EDGE, 6'd2, 6'd2, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_QUERY_EDGE, 6'd0, 6'd0, 5'd2, 5'd0);
        send_command(ams_pkg::CMD_DEL_EDGE, 6'd3, 6'd1, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_QUERY_EDGE, 6'd0, 6'd0, 5'd0, 5'd2);
        send_command(ams_pkg::CMD_ADD_EDGE, 6'd2, 6'd3, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_DEL_VERTEX, 6'd1, 6'd0, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_QUERY_EDGE, 6'd0, 6'd0, 5'd0, 5'd1);
        // new vertex takes name 3, which the shifted vertex already has
        send_command(ams_pkg::CMD_ADD_VERTEX, 6'd0, 6'd0, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_DEL_EDGE, 6'd3, 6'd2, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_QUERY_NAME, 6'd0, 6'd0, 5'd2, 5'd0);
    endtask

    // oversized start count saturates to a full store
    task automatic test_full_store();
        wait_until_drained();
        write_start_count(6'd33);
        send_command(ams_pkg::CMD_ADD_VERTEX, 6'd0, 6'd0, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_QUERY_NAME, 6'd0, 6'd0, 5'd31, 5'd0);
        send_command(ams_pkg::CMD_ADD_EDGE, 6'd32, 6'd1, 5'd0, 5'd0);
        send_command(ams_pkg::CMD_QUERY_EDGE, 6'd0, 6'd0, 5'd31, 5'd0);
        send_command(ams_pkg::CMD_DEL_VERTEX, 6'd63, 6'd0, 5'd0, 5'd0);
    endtask

    // random traffic from a fresh store under one idling pattern
    task automatic test_random_traffic(input logic [ams_pkg::NAME_W-1:0] start,
                                       input int idle_pct, input int stall_pct);
        wait_until_drained();
        write_start_count(start);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        repeat (PHASE_BEATS) send_random_command();
    endtask

    // sender holds off mid-stream until the pipeline is empty
    task automatic test_drain_pause();
        sender_idle_pct = 0;
        sink_stall_pct  = 30;
        repeat (8) send_random_command();
        wait_until_drained();
        repeat (8) send_random_command();
    endtask

    // test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_edges_and_compaction();
        test_full_store();
        test_random_traffic(6'd0, 0, 0);
        test_random_traffic(6'd32, 71, 0);
        test_drain_pause();
        test_random_traffic(ams_pkg::NAME_W'($urandom_range(1, 31)), 0, 71);
        test_random_traffic(6'd63, 6, 6);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d commands sent, %0d results checked, %0d store rebuilds",
                 commands_sent, results_checked, rebuilds);
        $display("     %0d vertex deletes with compaction, %0d adds refused on a full store",
                 vertex_deletes, full_rejects);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/ams_pkg.sv
design/ams_store.sv
design/adjacency_matrix_store.sv
tb/sv/adjacency_matrix_store_test.sv
